// File: rtl/apct_pkg.sv
// shared types and constants for the rectangle pair collision table
// used by apct_ctrl, apct_dp and aabb_pair_collision_table; no dependencies
package apct_pkg;

  localparam int SLOTS_DEF = 32;

  localparam int SLOT_W  = 5;
  localparam int POS_W   = 16;
  localparam int SIZE_W  = 15;
  localparam int KIND_W  = 4;
  localparam int MASK_W  = 32;
  localparam int FLOW_W  = 60;
  localparam int FHIGH_W = 40;
  localparam int CDATA_W = 64;
  localparam int CIDX_W  = 1;

  localparam logic [KIND_W-1:0] KIND_MAX = 4'd9;

  localparam logic [CIDX_W-1:0] CFG_FILTER_LOW  = 1'b0;
  localparam logic [CIDX_W-1:0] CFG_FILTER_HIGH = 1'b1;

  typedef enum logic [1:0] {
    MODE_ADD  = 2'd0,
    MODE_FREE = 2'd1,
    MODE_SCAN = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ADD_FIND,
    ST_SCAN_ROW,
    ST_SCAN_LOOP,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic signed [POS_W-1:0] left;
    logic signed [POS_W-1:0] top;
    logic [SIZE_W-1:0]       wide;
    logic [SIZE_W-1:0]       tall;
    logic [KIND_W-1:0]       kind;
    logic                    lis;
  } rect_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic cnt_zero;
    logic cnt_row;
    logic cnt_inc;
    logic add_write;
    logic add_full;
    logic do_free;
    logic rd_row;
    logic latch_row;
    logic scan_issue;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    mode_t mode;
    logic  row_ok;
    logic  cnt_end;
    logic  cnt_free;
    logic  pipe_busy;
  } sts_t;

endpackage

// File: rtl/apct_ctrl.sv
// sequencing state machine for the collision table
// depends on apct_pkg (state_t, cmd_t, sts_t, mode_t)
module apct_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  apct_pkg::sts_t  sts,
  output apct_pkg::cmd_t  cmd
);

  apct_pkg::state_t state_r, state_nxt;
  logic             out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= apct_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      apct_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = apct_pkg::ST_DECODE;
        end
      end
      apct_pkg::ST_DECODE: begin
        unique case (sts.mode)
          apct_pkg::MODE_ADD: begin
            cmd.cnt_zero = 1'b1;
            state_nxt    = apct_pkg::ST_ADD_FIND;
          end
          apct_pkg::MODE_FREE: begin
            cmd.do_free = 1'b1;
            state_nxt   = apct_pkg::ST_RESULT;
          end
          apct_pkg::MODE_SCAN: begin
            if (sts.row_ok) begin
              cmd.rd_row  = 1'b1;
              cmd.cnt_row = 1'b1;
              state_nxt   = apct_pkg::ST_SCAN_ROW;
            end else begin
              state_nxt = apct_pkg::ST_RESULT;
            end
          end
          apct_pkg::MODE_NONE: begin
            state_nxt = apct_pkg::ST_RESULT;
          end
          default: begin
            state_nxt = apct_pkg::ST_RESULT;
          end
        endcase
      end
      apct_pkg::ST_ADD_FIND: begin
        // walk the used bits from slot zero up to the first hole
        if (sts.cnt_end) begin
          cmd.add_full = 1'b1;
          state_nxt    = apct_pkg::ST_RESULT;
        end else if (sts.cnt_free) begin
          cmd.add_write = 1'b1;
          state_nxt     = apct_pkg::ST_RESULT;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      apct_pkg::ST_SCAN_ROW: begin
        cmd.latch_row = 1'b1;
        state_nxt     = apct_pkg::ST_SCAN_LOOP;
      end
      apct_pkg::ST_SCAN_LOOP: begin
        cmd.scan_issue = 1'b1;
        // wait for the last compare to leave the pipe
        if (sts.cnt_end && !sts.pipe_busy) begin
          state_nxt = apct_pkg::ST_RESULT;
        end
      end
      apct_pkg::ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = apct_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = apct_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/apct_dp.sv
// datapath: rectangle memory, used bits, filter registers, scan compare and result regs
// depends on apct_pkg; driven by apct_ctrl through cmd_t / sts_t
module apct_dp #(
  parameter int SLOTS = apct_pkg::SLOTS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [1:0]                             in_mode,
  input  logic [apct_pkg::SLOT_W-1:0]            in_slot,
  input  logic signed [apct_pkg::POS_W-1:0]      in_x_pos,
  input  logic signed [apct_pkg::POS_W-1:0]      in_y_pos,
  input  logic [apct_pkg::SIZE_W-1:0]            in_width,
  input  logic [apct_pkg::SIZE_W-1:0]            in_height,
  input  logic [apct_pkg::KIND_W-1:0]            in_kind,
  input  logic                                   in_listens,
  input  logic                                   cfg_valid,
  input  logic [apct_pkg::CIDX_W-1:0]            cfg_index,
  input  logic [apct_pkg::CDATA_W-1:0]           cfg_data,
  input  apct_pkg::cmd_t                         cmd,
  output apct_pkg::sts_t                         sts,
  output logic [apct_pkg::SLOT_W-1:0]            out_slot_given,
  output logic                                   out_table_full,
  output logic [apct_pkg::MASK_W-1:0]            out_forward_mask,
  output logic [apct_pkg::MASK_W-1:0]            out_reverse_mask
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CMP_W = apct_pkg::SLOT_W + 2;
  localparam int EXT_W = apct_pkg::POS_W + 2;

  // captured item
  apct_pkg::mode_t             mode_r;
  logic [apct_pkg::SLOT_W-1:0] slot_r;
  apct_pkg::rect_t             item_r;

  // table state
  logic [SLOTS-1:0]            used_r;
  apct_pkg::rect_t             mem [SLOTS];
  apct_pkg::rect_t             rd_q;
  apct_pkg::rect_t             row_r;

  logic [apct_pkg::FLOW_W-1:0]  filt_low_r;
  logic [apct_pkg::FHIGH_W-1:0] filt_high_r;

  logic [CNT_W-1:0]            cnt_r;
  logic                        pipe_v_r;
  logic                        pipe_used_r;
  logic [IDX_W-1:0]            pipe_k_r;

  logic [apct_pkg::SLOT_W-1:0] given_r;
  logic                        full_r;
  logic [apct_pkg::MASK_W-1:0] fwd_r;
  logic [apct_pkg::MASK_W-1:0] rev_r;

  logic [apct_pkg::SLOT_W-1:0] out_given_r;
  logic                        out_full_r;
  logic [apct_pkg::MASK_W-1:0] out_fwd_r;
  logic [apct_pkg::MASK_W-1:0] out_rev_r;

  logic [IDX_W-1:0]            slot_idx;
  logic [IDX_W-1:0]            cnt_idx;
  logic [IDX_W-1:0]            rd_addr;
  logic                        slot_in_range;
  logic                        cnt_end;
  logic [99:0]                 filt_mat;
  logic                        hit;
  logic                        hit_fwd;
  logic                        hit_rev;

  function automatic logic rect_overlap(apct_pkg::rect_t a, apct_pkg::rect_t b);
    logic signed [EXT_W-1:0] ax, ay, bx, by;
    logic signed [EXT_W-1:0] ax_end, ay_end, bx_end, by_end;
    ax     = {{2{a.left[apct_pkg::POS_W-1]}}, a.left};
    ay     = {{2{a.top[apct_pkg::POS_W-1]}}, a.top};
    bx     = {{2{b.left[apct_pkg::POS_W-1]}}, b.left};
    by     = {{2{b.top[apct_pkg::POS_W-1]}}, b.top};
    ax_end = ax + $signed({3'b000, a.wide});
    ay_end = ay + $signed({3'b000, a.tall});
    bx_end = bx + $signed({3'b000, b.wide});
    by_end = by + $signed({3'b000, b.tall});
    // touching edges still count as a hit
    return !((ax_end < bx) || (bx_end < ax) || (ay_end < by) || (by_end < ay));
  endfunction

  // rows of the matrix sit ten bits apart across both registers
  function automatic logic filter_bit(logic [99:0] m, logic [apct_pkg::KIND_W-1:0] r,
                                      logic [apct_pkg::KIND_W-1:0] c);
    logic [6:0] idx;
    idx = 7'(r) * 7'd10 + 7'(c);
    if ((r > apct_pkg::KIND_MAX) || (c > apct_pkg::KIND_MAX)) begin
      return 1'b0;
    end
    return m[idx];
  endfunction

  assign slot_idx      = IDX_W'(slot_r);
  assign cnt_idx       = cnt_r[IDX_W-1:0];
  assign slot_in_range = ({2'b00, slot_r} < CMP_W'(SLOTS));
  assign cnt_end       = (cnt_r == CNT_W'(SLOTS));
  assign rd_addr       = cmd.rd_row ? slot_idx : cnt_idx;
  assign filt_mat      = {filt_high_r, filt_low_r};

  assign hit     = pipe_v_r && pipe_used_r && rect_overlap(row_r, rd_q);
  assign hit_fwd = hit && row_r.lis && filter_bit(filt_mat, row_r.kind, rd_q.kind);
  assign hit_rev = hit && rd_q.lis && filter_bit(filt_mat, rd_q.kind, row_r.kind);

  assign sts.mode      = mode_r;
  assign sts.row_ok    = slot_in_range && used_r[slot_idx];
  assign sts.cnt_end   = cnt_end;
  assign sts.cnt_free  = !used_r[cnt_idx];
  assign sts.pipe_busy = pipe_v_r;

  // filter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_low_r  <= '0;
      filt_high_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        apct_pkg::CFG_FILTER_LOW:  filt_low_r  <= cfg_data[apct_pkg::FLOW_W-1:0];
        apct_pkg::CFG_FILTER_HIGH: filt_high_r <= cfg_data[apct_pkg::FHIGH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // rectangle memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.add_write) begin
      mem[cnt_idx] <= item_r;
    end
    rd_q <= mem[rd_addr];
  end

  // control side of the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= apct_pkg::MODE_NONE;
      used_r   <= '0;
      cnt_r    <= '0;
      pipe_v_r <= 1'b0;
    end else begin
      if (cmd.capture) begin
        mode_r <= apct_pkg::mode_t'(in_mode);
      end
      if (cmd.add_write) begin
        used_r[cnt_idx] <= 1'b1;
      end
      if (cmd.do_free && slot_in_range) begin
        used_r[slot_idx] <= 1'b0;
      end
      pipe_v_r <= cmd.scan_issue && !cnt_end;
      if (cmd.cnt_zero) begin
        cnt_r <= '0;
      end else if (cmd.cnt_row) begin
        cnt_r <= CNT_W'({1'b0, slot_r} + 6'd1);
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (cmd.scan_issue && !cnt_end) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      slot_r      <= in_slot;
      item_r.left <= in_x_pos;
      item_r.top  <= in_y_pos;
      item_r.wide <= in_width;
      item_r.tall <= in_height;
      item_r.kind <= in_kind;
      item_r.lis  <= in_listens;
      given_r     <= '0;
      full_r      <= 1'b0;
      fwd_r       <= '0;
      rev_r       <= '0;
    end
    if (cmd.add_write) begin
      given_r <= apct_pkg::SLOT_W'(cnt_r);
    end
    if (cmd.add_full) begin
      full_r <= 1'b1;
    end
    if (cmd.latch_row) begin
      row_r <= rd_q;
    end
    if (cmd.scan_issue && !cnt_end) begin
      pipe_k_r    <= cnt_idx;
      pipe_used_r <= used_r[cnt_idx];
    end
    // slots above the mask width shift out and are dropped
    if (hit_fwd) begin
      fwd_r <= fwd_r | (apct_pkg::MASK_W'(1) << pipe_k_r);
    end
    if (hit_rev) begin
      rev_r <= rev_r | (apct_pkg::MASK_W'(1) << pipe_k_r);
    end
    if (cmd.load_out) begin
      out_given_r <= given_r;
      out_full_r  <= full_r;
      out_fwd_r   <= fwd_r;
      out_rev_r   <= rev_r;
    end
  end

  assign out_slot_given   = out_given_r;
  assign out_table_full   = out_full_r;
  assign out_forward_mask = out_fwd_r;
  assign out_reverse_mask = out_rev_r;

endmodule

// File: rtl/aabb_pair_collision_table.sv
// top level of the rectangle pair collision table: controller plus datapath
// depends on apct_pkg, apct_ctrl and apct_dp
//
//   channel  handshake              payload
//   in       in_valid / in_ready    mode, slot, x_pos, y_pos, width, height, kind, listens
//   out      out_valid / out_ready  slot_given, table_full, forward_mask, reverse_mask
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (0 filter low, 1 filter high)
//
// one item at a time; in_ready is high only while the controller is idle
// add: used bits tested from slot zero to the first hole or the end, one bit per cycle
// scan of row i: slots above i are checked, one stored slot read and compared per cycle
// free and other modes: no slot walk; the result register lets the next item in while
// a result waits; reset is synchronous, active low, and clears used bits and filters
module aabb_pair_collision_table #(
  parameter int SLOTS = apct_pkg::SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_mode,
  input  logic [apct_pkg::SLOT_W-1:0]         in_slot,
  input  logic signed [apct_pkg::POS_W-1:0]   in_x_pos,
  input  logic signed [apct_pkg::POS_W-1:0]   in_y_pos,
  input  logic [apct_pkg::SIZE_W-1:0]         in_width,
  input  logic [apct_pkg::SIZE_W-1:0]         in_height,
  input  logic [apct_pkg::KIND_W-1:0]         in_kind,
  input  logic                                in_listens,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [apct_pkg::SLOT_W-1:0]         out_slot_given,
  output logic                                out_table_full,
  output logic [apct_pkg::MASK_W-1:0]         out_forward_mask,
  output logic [apct_pkg::MASK_W-1:0]         out_reverse_mask,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [apct_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [apct_pkg::CDATA_W-1:0]        cfg_data
);

  apct_pkg::cmd_t cmd;
  apct_pkg::sts_t sts;

  // filter writes are always accepted and registered directly
  assign cfg_ready = 1'b1;

  apct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  apct_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mode          (in_mode),
    .in_slot          (in_slot),
    .in_x_pos         (in_x_pos),
    .in_y_pos         (in_y_pos),
    .in_width         (in_width),
    .in_height        (in_height),
    .in_kind          (in_kind),
    .in_listens       (in_listens),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .sts              (sts),
    .out_slot_given   (out_slot_given),
    .out_table_full   (out_table_full),
    .out_forward_mask (out_forward_mask),
    .out_reverse_mask (out_reverse_mask)
  );

endmodule
